// ===== src/pce_pkg.sv =====
// Package: shared types and codes for the pretrigger capture engine.
`timescale 1ns / 1ps

package pce_pkg;

    // Input request payload
    typedef struct packed {
        logic               action;
        logic signed [15:0] in_x;
        logic signed [15:0] in_y;
        logic signed [15:0] in_z;
        logic               event_seen;
    } in_item_t;

    // Output request payload
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_z;
        logic [23:0]        total_samples;
        logic [15:0]        capture_id;
        logic               last;
    } out_item_t;

    // Result kinds
    localparam logic [1:0] KIND_PRE      = 2'd0;
    localparam logic [1:0] KIND_LIVE     = 2'd1;
    localparam logic [1:0] KIND_COMPLETE = 2'd2;

    // Input actions
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_RING_CAPACITY = 2'd0;
    localparam logic [1:0] REG_DURATION      = 2'd1;
    localparam logic [1:0] REG_FIRST_NUMBER  = 2'd2;

    localparam logic [15:0] DURATION_RESET = 16'd1000;
    localparam logic [6:0]  CAPACITY_RESET = 7'd64;
    localparam logic [23:0] COUNT_MAX      = 24'hFFFFFF;
    localparam logic [15:0] ELAPSED_MAX    = 16'hFFFF;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DUMP_RD,
        ST_DUMP_OUT
    } ctrl_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;     // input request taken this cycle
        logic rd_en;      // read ring entry at dump address
        logic emit_dump;  // load read entry into output register
    } pce_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic slot_free;   // output register can take a result
        logic dump_start;  // pending input is a trigger sample while idle
        logic dump_final;  // one dump entry left
    } pce_sts_t;

endpackage

// ===== src/pretrigger_capture_engine_top.sv =====
// A live or completion result sits in the output register in the cycle after its request is accepted.
// A trigger dumps the ring one stored sample at a time: memory read, then output load, which waits on a stall.
// Throughput: one request per cycle outside dumps while the output is taken.
// The dump sequencer and the single-port registered ring read set the dump rate.
// Reset: asynchronous, clears pointers, counters and state; ring contents stay undefined,
// no clearing pass is run.
`timescale 1ns / 1ps

module pretrigger_capture_engine_top #(
    parameter int RING_DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  pce_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output pce_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import pce_pkg::*;

    pce_cmd_t cmd;
    pce_sts_t sts;

    assign cfg_ready = 1'b1;

    // Sequencer
    pce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Ring and counters
    pce_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // Ring reads never issue back to back
    a_rd_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |=> !cmd.rd_en)
        else $error("ring read issued on consecutive cycles");

    // No request accepted while a dump entry is pending
    a_no_accept_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |=> !cmd.accept)
        else $error("request accepted during dump");

    // Accept and dump load never coincide
    a_accept_vs_dump: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.accept && cmd.emit_dump))
        else $error("accept and dump load in one cycle");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

endmodule

// ===== src/pce_ctrl.sv =====
// Controller: input acceptance and pre-event dump sequencing.
`timescale 1ns / 1ps

module pce_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  pce_pkg::pce_sts_t sts,
    output pce_pkg::pce_cmd_t cmd
);
    import pce_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        in_stall      = 1'b1;
        cmd.accept    = 1'b0;
        cmd.rd_en     = 1'b0;
        cmd.emit_dump = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall   = !sts.slot_free;
                cmd.accept = in_valid && sts.slot_free;
                if (cmd.accept && sts.dump_start)
                begin
                    state_next = ST_DUMP_RD;
                end
            end
            ST_DUMP_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_DUMP_OUT;
            end
            ST_DUMP_OUT:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit_dump = 1'b1;
                    state_next    = sts.dump_final ? ST_IDLE : ST_DUMP_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/pce_datapath.sv =====
// Datapath: ring memory, pointers, capture counters and output register.
`timescale 1ns / 1ps

module pce_datapath #(
    parameter int RING_DEPTH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pce_pkg::in_item_t   in_data,
    input  pce_pkg::pce_cmd_t   cmd,
    output pce_pkg::pce_sts_t   sts,
    input  logic                cfg_valid,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output logic                out_valid,
    input  logic                out_stall,
    output pce_pkg::out_item_t  out_data
);
    import pce_pkg::*;

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int EW    = (CNT_W > 7) ? CNT_W : 7;
    localparam logic [EW-1:0] DEPTH_E = EW'(RING_DEPTH);

    // Ring memory
    logic [47:0] ring_mem [RING_DEPTH];
    logic [47:0] rd_data_reg;

    // Configuration and control state
    logic [6:0]       cap_cfg_reg;
    logic [15:0]      duration_reg;
    logic [PTR_W-1:0] wp_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             capturing_reg;
    logic [15:0]      elapsed_reg;
    logic [23:0]      captured_reg;
    logic [15:0]      counter_reg;
    logic [PTR_W-1:0] rd_addr_reg;
    logic [CNT_W-1:0] dump_left_reg;
    logic             out_valid_reg;
    out_item_t        out_reg;

    logic [EW-1:0]    cap_ext;
    logic [CNT_W-1:0] cap_eff;
    logic [CNT_W-1:0] wp_ext;
    logic [CNT_W-1:0] wp_sub;
    logic [CNT_W-1:0] wp_inc;
    logic [CNT_W-1:0] wp_new;
    logic [CNT_W-1:0] fill_new;
    logic [CNT_W-1:0] start_addr;
    logic [CNT_W-1:0] rd_inc;
    logic             sample_acc;
    logic             tick_acc;
    logic             cap_write;
    logic             done_now;

    // Effective capacity: zero acts as one, clamped to the ring depth
    always_comb
    begin
        cap_ext = EW'(cap_cfg_reg);
        if (cap_ext == '0)
        begin
            cap_eff = CNT_W'(1);
        end
        else if (cap_ext > DEPTH_E)
        begin
            cap_eff = CNT_W'(RING_DEPTH);
        end
        else
        begin
            cap_eff = CNT_W'(cap_ext);
        end
    end

    // Write pointer and fill count for an incoming sample
    always_comb
    begin
        wp_ext   = CNT_W'(wp_reg);
        wp_sub   = (wp_ext >= cap_eff) ? '0 : wp_ext;
        wp_inc   = wp_sub + CNT_W'(1);
        wp_new   = (wp_inc == cap_eff) ? '0 : wp_inc;
        fill_new = (fill_reg < cap_eff) ? fill_reg + CNT_W'(1) : fill_reg;
        if (wp_new >= fill_new)
        begin
            start_addr = wp_new - fill_new;
        end
        else
        begin
            start_addr = cap_eff - (fill_new - wp_new);
        end
        rd_inc = CNT_W'(rd_addr_reg) + CNT_W'(1);
    end

    assign sample_acc = cmd.accept && (in_data.action == ACT_SAMPLE);
    assign tick_acc   = cmd.accept && (in_data.action == ACT_TICK);
    assign cap_write  = cfg_valid && (cfg_index == REG_RING_CAPACITY);
    assign done_now   = capturing_reg && (elapsed_reg >= duration_reg);

    // Status to controller
    assign sts.slot_free  = !out_valid_reg || !out_stall;
    assign sts.dump_start = (in_data.action == ACT_SAMPLE) && in_data.event_seen
                            && !capturing_reg;
    assign sts.dump_final = (dump_left_reg == CNT_W'(1));

    // Ring write and registered read
    always_ff @(posedge clk)
    begin
        if (sample_acc)
        begin
            ring_mem[wp_sub[PTR_W-1:0]] <= {in_data.in_z, in_data.in_y, in_data.in_x};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= ring_mem[rd_addr_reg];
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_cfg_reg  <= CAPACITY_RESET;
            duration_reg <= DURATION_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_RING_CAPACITY: cap_cfg_reg  <= cfg_data[6:0];
                REG_DURATION:      duration_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Ring pointers, capture state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            fill_reg      <= '0;
            capturing_reg <= 1'b0;
            elapsed_reg   <= '0;
            captured_reg  <= '0;
            counter_reg   <= '0;
            rd_addr_reg   <= '0;
            dump_left_reg <= '0;
        end
        else
        begin
            if (cap_write)
            begin
                wp_reg   <= '0;
                fill_reg <= '0;
            end
            if (cfg_valid && (cfg_index == REG_FIRST_NUMBER))
            begin
                counter_reg <= cfg_data;
            end
            // Millisecond tick
            if (tick_acc && capturing_reg && (elapsed_reg != ELAPSED_MAX))
            begin
                elapsed_reg <= elapsed_reg + 16'd1;
            end
            // Sample
            if (sample_acc)
            begin
                wp_reg   <= wp_new[PTR_W-1:0];
                fill_reg <= fill_new;
                if (!capturing_reg)
                begin
                    if (in_data.event_seen)
                    begin
                        rd_addr_reg   <= start_addr[PTR_W-1:0];
                        dump_left_reg <= fill_new;
                        captured_reg  <= 24'(fill_new);
                        fill_reg      <= '0;
                        capturing_reg <= 1'b1;
                        elapsed_reg   <= '0;
                    end
                end
                else if (done_now)
                begin
                    counter_reg   <= counter_reg + 16'd1;
                    capturing_reg <= 1'b0;
                    elapsed_reg   <= '0;
                    captured_reg  <= '0;
                end
                else if (captured_reg != COUNT_MAX)
                begin
                    captured_reg <= captured_reg + 24'd1;
                end
            end
            // Dump walk
            if (cmd.emit_dump)
            begin
                dump_left_reg <= dump_left_reg - CNT_W'(1);
                rd_addr_reg   <= (rd_inc == cap_eff) ? '0 : rd_inc[PTR_W-1:0];
            end
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_dump || (sample_acc && capturing_reg))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit_dump)
        begin
            out_reg.kind          <= KIND_PRE;
            out_reg.out_x         <= rd_data_reg[15:0];
            out_reg.out_y         <= rd_data_reg[31:16];
            out_reg.out_z         <= rd_data_reg[47:32];
            out_reg.total_samples <= '0;
            out_reg.capture_id    <= '0;
            out_reg.last          <= sts.dump_final;
        end
        else if (sample_acc && capturing_reg)
        begin
            out_reg.last <= 1'b1;
            if (done_now)
            begin
                out_reg.kind          <= KIND_COMPLETE;
                out_reg.out_x         <= '0;
                out_reg.out_y         <= '0;
                out_reg.out_z         <= '0;
                out_reg.total_samples <= captured_reg;
                out_reg.capture_id    <= counter_reg;
            end
            else
            begin
                out_reg.kind          <= KIND_LIVE;
                out_reg.out_x         <= in_data.in_x;
                out_reg.out_y         <= in_data.in_y;
                out_reg.out_z         <= in_data.in_z;
                out_reg.total_samples <= '0;
                out_reg.capture_id    <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== sim/tb_top.sv =====
// Testbench for the pretrigger capture engine: random and directed requests checked in order.
`timescale 1ns / 1ps

module tb_top;
    import pce_pkg::*;

    localparam int RING_DEPTH    = 64;
    localparam int SETTLE_CYCLES = 8;    // quiet cycles before a register write and at the end
    localparam int PHASE_ITEMS   = 80;   // least number of requests per random phase

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    in_item_t    in_data   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_RING_CAPACITY;
    logic [15:0] cfg_data  = '0;

    int send_idle_pct   = 0;
    int stall_pct       = 0;
    int error_count     = 0;
    int requests_sent   = 0;
    int results_checked = 0;
    int captures_done   = 0;

    // Predictor state and register shadows
    logic [47:0] ring_mem [RING_DEPTH];
    int unsigned wr_ptr;
    int unsigned fill_cnt;
    int unsigned ms_count;
    int unsigned sample_total;
    bit          capture_active;
    logic [15:0] capture_num;
    logic [6:0]  capacity_reg;
    logic [15:0] duration_reg;
    out_item_t   due_results [$];
    out_item_t   want;

    pretrigger_capture_engine_top #(
        .RING_DEPTH(RING_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Receiver back-pressure
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    function automatic void reset_model();
        capacity_reg   = CAPACITY_RESET;
        duration_reg   = DURATION_RESET;
        capture_num    = '0;
        wr_ptr         = 0;
        fill_cnt       = 0;
        ms_count       = 0;
        sample_total   = 0;
        capture_active = 1'b0;
    endfunction

    // Effective pre-event window: zero acts as one, clamp at ring depth
    function automatic int unsigned window_len();
        if (capacity_reg == 0)
            return 1;
        if (capacity_reg > RING_DEPTH)
            return RING_DEPTH;
        return 32'(capacity_reg);
    endfunction

    function automatic out_item_t make_result(logic [1:0] kind, logic [47:0] xyz,
                                              int unsigned total, logic [15:0] num);
        out_item_t r;
        r.kind          = kind;
        r.out_x         = xyz[15:0];
        r.out_y         = xyz[31:16];
        r.out_z         = xyz[47:32];
        r.total_samples = total[23:0];
        r.capture_id    = num;
        r.last          = 1'b0;
        return r;
    endfunction

    // Work out the results one accepted request causes
    function automatic void predict_capture(in_item_t req);
        int unsigned depth;
        int unsigned start;
        int unsigned i;
        int unsigned n_before;
        logic [47:0] xyz;
        out_item_t   tail;
        depth = window_len();
        if (req.action == ACT_TICK)
        begin
            if (capture_active && ms_count < ELAPSED_MAX)
                ms_count++;
            return;
        end
        n_before = due_results.size();
        xyz = {req.in_z, req.in_y, req.in_x};
        if (wr_ptr >= depth)
            wr_ptr = 0;
        ring_mem[wr_ptr] = xyz;
        wr_ptr = (wr_ptr + 1) % depth;
        if (fill_cnt < depth)
            fill_cnt++;
        if (!capture_active)
        begin
            if (req.event_seen)
            begin
                // dump oldest first; the trigger sample is the final entry
                start = (wr_ptr + depth - fill_cnt) % depth;
                for (i = 0; i < fill_cnt; i++)
                    due_results.push_back(make_result(KIND_PRE,
                        ring_mem[(start + i) % depth], 0, '0));
                sample_total   = fill_cnt;
                fill_cnt       = 0;
                capture_active = 1'b1;
                ms_count       = 0;
            end
        end
        else if (ms_count >= duration_reg)
        begin
            due_results.push_back(make_result(KIND_COMPLETE, '0, sample_total, capture_num));
            capture_num++;
            captures_done++;
            capture_active = 1'b0;
            ms_count       = 0;
            sample_total   = 0;
        end
        else
        begin
            due_results.push_back(make_result(KIND_LIVE, xyz, 0, '0));
            if (sample_total < COUNT_MAX)
                sample_total++;
        end
        if (due_results.size() > n_before)
        begin
            tail = due_results.pop_back();
            tail.last = 1'b1;
            due_results.push_back(tail);
        end
    endfunction

    function automatic void check_field(string name, logic signed [31:0] exp_v,
                                        logic signed [31:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
            error_count++;
        end
    endfunction

    // Scoreboard: each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_results.size() == 0)
            begin
                $error("unexpected result: kind %0d with nothing due", out_data.kind);
                error_count++;
            end
            else
            begin
                want = due_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(out_data.kind));
                check_field("out_x", 32'(want.out_x), 32'(out_data.out_x));
                check_field("out_y", 32'(want.out_y), 32'(out_data.out_y));
                check_field("out_z", 32'(want.out_z), 32'(out_data.out_z));
                check_field("total_samples", 32'(want.total_samples),
                            32'(out_data.total_samples));
                check_field("capture_id", 32'(want.capture_id), 32'(out_data.capture_id));
                check_field("last", 32'(want.last), 32'(out_data.last));
                results_checked++;
            end
        end
    end

    function automatic in_item_t make_item(logic act, logic ev);
        in_item_t r;
        r.action     = act;
        r.in_x       = 16'($urandom);
        r.in_y       = 16'($urandom);
        r.in_z       = 16'($urandom);
        r.event_seen = ev;
        return r;
    endfunction

    function automatic in_item_t sample_of(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                                           logic ev);
        in_item_t r;
        r.action     = ACT_SAMPLE;
        r.in_x       = x;
        r.in_y       = y;
        r.in_z       = z;
        r.event_seen = ev;
        return r;
    endfunction

    // One input request; valid stays high afterwards unless the next one idles first
    task automatic send_item(input in_item_t req);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (in_stall);
        predict_capture(req);
        requests_sent++;
    endtask

    // Wait until every expected result has arrived
    task automatic drain();
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
    endtask

    // Register write, only issued with the block quiet
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_RING_CAPACITY:
            begin
                capacity_reg = val[6:0];
                wr_ptr       = 0;
                fill_cnt     = 0;
            end
            REG_DURATION:     duration_reg = val;
            REG_FIRST_NUMBER: capture_num  = val;
            default:          ;
        endcase
    endtask

    // Reset values: full window, long duration; extremes of the axes
    task automatic test_reset_defaults();
        send_item(sample_of(16'h7FFF, 16'h8000, 16'h0000, 1'b0));
        send_item(make_item(ACT_TICK, 1'b1));     // tick while idle does nothing
        send_item(sample_of(16'h8000, 16'h7FFF, 16'hFFFF, 1'b0));
        send_item(sample_of(16'h0001, 16'hFFFE, 16'h5555, 1'b1));
        send_item(sample_of(16'hAAAA, 16'h5555, 16'h8001, 1'b1)); // event while capturing
        send_item(make_item(ACT_TICK, 1'b0));
        drain();
    endtask

    // Short duration: completion, then the completion sample shows up in the next dump
    task automatic test_short_capture();
        write_reg(REG_DURATION, 16'd2);
        send_item(make_item(ACT_TICK, 1'b0));
        send_item(sample_of(16'h1234, 16'h5678, 16'h9ABC, 1'b0));
        send_item(sample_of(16'hFFFF, 16'h0000, 16'h7FFF, 1'b0));
        send_item(sample_of(16'h0F0F, 16'hF0F0, 16'h8000, 1'b1));
        drain();
    endtask

    // Zero capacity acts as one; zero duration completes on the next sample
    task automatic test_zero_capacity();
        write_reg(REG_DURATION, 16'd0);
        write_reg(REG_RING_CAPACITY, 16'hFF80);
        send_item(make_item(ACT_SAMPLE, 1'b0));
        send_item(make_item(ACT_SAMPLE, 1'b0));
        send_item(make_item(ACT_SAMPLE, 1'b0));
        send_item(make_item(ACT_SAMPLE, 1'b1));
        send_item(make_item(ACT_SAMPLE, 1'b1));
        drain();
    endtask

    // Capture number wraps after the top value
    task automatic test_number_wrap();
        write_reg(REG_FIRST_NUMBER, 16'hFFFF);
        send_item(make_item(ACT_SAMPLE, 1'b1));
        send_item(make_item(ACT_SAMPLE, 1'b0));
        send_item(make_item(ACT_SAMPLE, 1'b1));
        send_item(make_item(ACT_SAMPLE, 1'b0));
        drain();
    endtask

    // Pre-fill, trigger, live samples and ticks until completion or a guard of 60 requests, with some noise
    task automatic run_capture_sequence();
        int unsigned depth;
        int unsigned n_pre;
        int unsigned guard;
        depth = window_len();
        n_pre = ($urandom_range(0, 5) == 0) ? $urandom_range(depth, depth + 8)
                                            : $urandom_range(0, 6);
        repeat (n_pre)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(make_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
            else
                send_item(make_item(ACT_SAMPLE, 1'b0));
        end
        send_item(make_item(ACT_SAMPLE, 1'b1));
        guard = 0;
        while (capture_active && guard < 60)
        begin
            if ($urandom_range(0, 99) < 45)
                send_item(make_item(ACT_TICK, 1'($urandom_range(0, 1))));
            else
                send_item(make_item(ACT_SAMPLE, $urandom_range(0, 4) == 0));
            guard++;
        end
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_v,
                                    input logic [6:0] cap);
        int          sent_at_start;
        logic [8:0]  upper;
        send_idle_pct = idle_pct;
        stall_pct     = stall_v;
        upper         = 9'($urandom);
        write_reg(REG_RING_CAPACITY, {upper, cap});
        write_reg(REG_DURATION, 16'($urandom_range(0, 5)));
        write_reg(REG_FIRST_NUMBER, 16'($urandom_range(0, 65535)));
        sent_at_start = requests_sent;
        while (requests_sent - sent_at_start < PHASE_ITEMS)
            run_capture_sequence();
        drain();
    endtask

    initial
    begin
        reset_model();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_short_capture();
        test_zero_capacity();
        test_number_wrap();

        run_random_phase(0, 0, 7'd64);
        run_random_phase(65, 0, 7'd127);
        run_random_phase(0, 65, 7'd1);
        run_random_phase(28, 28, 7'($urandom_range(2, 63)));

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Covered reset defaults, zero and clamped windows, capture number wrap");
        $display("and four idling mixes: %0d requests, %0d results, %0d captures",
                 requests_sent, results_checked, captures_done);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog: 50 ms of simulated time
    initial
    begin
        #50_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
